// ===== rtl/flba_pkg.sv =====
// Shared types and constants for the free-list entry allocator.
// Used by flba_ctrl, flba_dp and free_list_block_allocator; no dependencies.
package flba_pkg;

  // Pool geometry.
  localparam int ENTRIES  = 1024;
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int LINK_W   = IDX_W + 1;
  localparam int CAP_W    = IDX_W + 1;
  localparam int TAG_W    = 8;

  // Link value that terminates the free list.
  localparam logic [LINK_W-1:0] END_MARK = {LINK_W{1'b1}};
  localparam logic [CAP_W-1:0]  CAP_MAX  = CAP_W'(ENTRIES);
  localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(1024);

  // Item kinds.
  localparam logic [1:0] KIND_INIT    = 2'd0;
  localparam logic [1:0] KIND_ALLOC   = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // latch the item and start its work
    logic alloc_rd;   // read the link of the current head
    logic walk_start; // clear the initialize walk index
    logic walk_step;  // write one link during initialize
    logic commit;     // update the list state and load the result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cap_zero;   // clamped capacity is zero
    logic walk_last;  // walk index is at the last entry
  } status_t;

endpackage

// ===== rtl/flba_ctrl.sv =====
// Controller state machine of the free-list entry allocator.
// Depends on flba_pkg for the command and status structs and kind codes.
module flba_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         kind,
  output logic               out_valid,
  input  logic               out_ready,
  input  flba_pkg::status_t  status,
  output flba_pkg::cmd_t     cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       in_xfer;
  logic       slot_free;

  assign in_ready  = (state == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  // Command decode and next state.
  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.accept     = in_xfer;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          if (kind == flba_pkg::KIND_INIT) begin
            cmd.walk_start = 1'b1;
            state_next = status.cap_zero ? ST_DONE : ST_WALK;
          end else begin
            cmd.alloc_rd = (kind == flba_pkg::KIND_ALLOC);
            state_next = ST_DONE;
          end
        end
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
        if (status.walk_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and result valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/flba_dp.sv =====
// Datapath of the free-list entry allocator: link memory, list state, result.
// Depends on flba_pkg for widths, constants and the command and status structs.
module flba_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [flba_pkg::CAP_W-1:0]    cfg_wdata,
  input  logic [1:0]                    kind,
  input  logic [flba_pkg::IDX_W-1:0]    release_index,
  input  flba_pkg::cmd_t                cmd,
  output flba_pkg::status_t             status,
  output logic [flba_pkg::IDX_W-1:0]    granted_index,
  output logic                          granted,
  output logic [flba_pkg::CAP_W-1:0]    free_count,
  output logic                          is_empty,
  output logic [flba_pkg::TAG_W-1:0]    version_tag,
  output logic                          bad_index
);

  logic [flba_pkg::LINK_W-1:0] link_mem [flba_pkg::ENTRIES];

  logic [flba_pkg::CAP_W-1:0]  capacity;
  logic [flba_pkg::CAP_W-1:0]  active_cap;
  logic [flba_pkg::LINK_W-1:0] head;
  logic [flba_pkg::TAG_W-1:0]  tag;
  logic [flba_pkg::CAP_W-1:0]  fcount;
  logic [1:0]                  op_kind;
  logic [flba_pkg::IDX_W-1:0]  op_rel;
  logic [flba_pkg::IDX_W-1:0]  walk_idx;
  logic [flba_pkg::LINK_W-1:0] rd_link;

  logic [flba_pkg::CAP_W-1:0]  cap_clamp;
  logic [flba_pkg::CAP_W-1:0]  cap_less1;
  logic [flba_pkg::LINK_W-1:0] head_next;
  logic [flba_pkg::TAG_W-1:0]  tag_next;
  logic [flba_pkg::CAP_W-1:0]  fcount_next;
  logic [flba_pkg::CAP_W-1:0]  active_next;
  logic                        grant_next;
  logic                        bad_next;
  logic                        push_ok;
  logic                        mem_we;
  logic [flba_pkg::IDX_W-1:0]  mem_waddr;
  logic [flba_pkg::LINK_W-1:0] mem_wdata;

  // Capacity used by initialize, limited to the pool size.
  assign cap_clamp = (capacity > flba_pkg::CAP_MAX) ? flba_pkg::CAP_MAX : capacity;
  assign cap_less1 = cap_clamp - flba_pkg::CAP_W'(1);

  assign status.cap_zero  = (cap_clamp == '0);
  assign status.walk_last = (walk_idx == cap_less1[flba_pkg::IDX_W-1:0]);

  // A release is in range only below the active capacity.
  assign push_ok = ({1'b0, op_rel} < active_cap);

  // Memory write port: initialize walk or release push.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = walk_idx;
    mem_wdata = flba_pkg::LINK_W'(walk_idx) + flba_pkg::LINK_W'(1);
    if (cmd.walk_step) begin
      mem_we = 1'b1;
      if (status.walk_last) begin
        mem_wdata = flba_pkg::END_MARK;
      end
    end else if (cmd.commit && op_kind == flba_pkg::KIND_RELEASE && push_ok) begin
      mem_we    = 1'b1;
      mem_waddr = op_rel;
      mem_wdata = head;
    end
  end

  // Next list state for the item being committed.
  always_comb begin
    head_next   = head;
    tag_next    = tag;
    fcount_next = fcount;
    active_next = active_cap;
    grant_next  = 1'b0;
    bad_next    = 1'b0;
    case (op_kind)
      flba_pkg::KIND_INIT: begin
        active_next = cap_clamp;
        tag_next    = '0;
        fcount_next = cap_clamp;
        head_next   = status.cap_zero ? flba_pkg::END_MARK : '0;
      end
      flba_pkg::KIND_ALLOC: begin
        if (head != flba_pkg::END_MARK && !head[flba_pkg::LINK_W-1]) begin
          grant_next = 1'b1;
          head_next  = rd_link;
          tag_next   = tag + flba_pkg::TAG_W'(1);
          if (fcount != '0) begin
            fcount_next = fcount - flba_pkg::CAP_W'(1);
          end
        end
      end
      flba_pkg::KIND_RELEASE: begin
        if (!push_ok) begin
          bad_next = 1'b1;
        end else begin
          head_next = flba_pkg::LINK_W'(op_rel);
          tag_next  = tag + flba_pkg::TAG_W'(1);
          if (fcount < active_cap) begin
            fcount_next = fcount + flba_pkg::CAP_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Link memory with a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.alloc_rd) begin
      rd_link <= link_mem[head[flba_pkg::IDX_W-1:0]];
    end
  end

  // Control state of the list.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= flba_pkg::CAP_RESET;
      active_cap <= '0;
      head       <= flba_pkg::END_MARK;
      tag        <= '0;
      fcount     <= '0;
    end else begin
      if (cfg_wen) begin
        capacity <= cfg_wdata;
      end
      if (cmd.commit) begin
        active_cap <= active_next;
        head       <= head_next;
        tag        <= tag_next;
        fcount     <= fcount_next;
      end
    end
  end

  // Item latch, walk index and result registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_kind <= kind;
      op_rel  <= release_index;
    end
    if (cmd.walk_start) begin
      walk_idx <= '0;
    end else if (cmd.walk_step) begin
      walk_idx <= walk_idx + flba_pkg::IDX_W'(1);
    end
    if (cmd.commit) begin
      granted_index <= grant_next ? head[flba_pkg::IDX_W-1:0] : '0;
      granted       <= grant_next;
      free_count    <= fcount_next;
      is_empty      <= (head_next == flba_pkg::END_MARK);
      version_tag   <= tag_next;
      bad_index     <= bad_next;
    end
  end

endmodule

// ===== rtl/free_list_block_allocator.sv =====
// Free-list entry allocator: allocate and release go from idle to the done state, where
// the result registers load on commit; a new item is taken only back in the idle state.
// Initialize writes one link per cycle in the walk state, then commits in the done state.
// An unread result stalls the commit of the next item.
// Synchronous reset empties the list, clears tag and counter, capacity 1024.
// Top level: joins flba_ctrl and flba_dp; depends on flba_pkg.
module free_list_block_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [flba_pkg::CAP_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    kind,
  input  logic [flba_pkg::IDX_W-1:0]    release_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [flba_pkg::IDX_W-1:0]    granted_index,
  output logic                          granted,
  output logic [flba_pkg::CAP_W-1:0]    free_count,
  output logic                          is_empty,
  output logic [flba_pkg::TAG_W-1:0]    version_tag,
  output logic                          bad_index
);

  flba_pkg::cmd_t    cmd;
  flba_pkg::status_t status;

  // Sequencing of transfers and commands.
  flba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Link memory, list state and result registers.
  flba_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .kind          (kind),
    .release_index (release_index),
    .cmd           (cmd),
    .status        (status),
    .granted_index (granted_index),
    .granted       (granted),
    .free_count    (free_count),
    .is_empty      (is_empty),
    .version_tag   (version_tag),
    .bad_index     (bad_index)
  );

endmodule
